### rtl/bsae_pkg.sv
// Shared constants, types and request codes of the bounded sorted array engine.
package bsae_pkg;

   localparam int CAPACITY = 64;
   localparam int KEY_W    = 32;
   localparam int TAG_W    = 16;
   localparam int POS_W    = 6;
   localparam int FILL_W   = 7;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int PTR_W    = (CNT_W > FILL_W) ? CNT_W : FILL_W;

   localparam logic [2:0] REQ_INSERT  = 3'd0;
   localparam logic [2:0] REQ_REMOVE  = 3'd1;
   localparam logic [2:0] REQ_CHECKED = 3'd2;
   localparam logic [2:0] REQ_POP     = 3'd3;
   localparam logic [2:0] REQ_CLEAR   = 3'd4;

   localparam logic [1:0] STAT_DONE = 2'd0;
   localparam logic [1:0] STAT_FULL = 2'd1;
   localparam logic [1:0] STAT_BAD  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_SEARCH
   } state_type;

   typedef struct packed {
      logic             ins;
      logic             rem;
      logic [PTR_W-1:0] at;
   } cell_ctrl_type;

endpackage

### rtl/bsae_cell.sv
// One storage cell of the sorted array: holds an entry, shifts, compares and drives the read bus.
module bsae_cell (
   input  logic                                 clock,
   input  bsae_pkg::cell_ctrl_type              ctrl,
   input  logic [bsae_pkg::PTR_W-1:0]           idx,
   input  logic signed [bsae_pkg::KEY_W-1:0]    new_key,
   input  logic [bsae_pkg::TAG_W-1:0]           new_tag,
   input  logic signed [bsae_pkg::KEY_W-1:0]    prev_key,
   input  logic [bsae_pkg::TAG_W-1:0]           prev_tag,
   input  logic signed [bsae_pkg::KEY_W-1:0]    next_key,
   input  logic [bsae_pkg::TAG_W-1:0]           next_tag,
   output logic signed [bsae_pkg::KEY_W-1:0]    key,
   output logic [bsae_pkg::TAG_W-1:0]           tag,
   output logic                                 lt_flag,
   output logic                                 eq_flag,
   output logic signed [bsae_pkg::KEY_W-1:0]    sel_key,
   output logic [bsae_pkg::TAG_W-1:0]           sel_tag
);

   logic signed [bsae_pkg::KEY_W-1:0] key_ff, key_in;
   logic [bsae_pkg::TAG_W-1:0]        tag_ff, tag_in;
   logic                              lt_ff, eq_ff;
   logic                              hit;

   assign hit = (idx == ctrl.at);

   always_comb begin
      key_in = key_ff;
      tag_in = tag_ff;
      if (ctrl.ins) begin
         if (idx > ctrl.at) begin
            key_in = prev_key;
            tag_in = prev_tag;
         end else if (hit) begin
            key_in = new_key;
            tag_in = new_tag;
         end
      end else if (ctrl.rem) begin
         if (idx >= ctrl.at) begin
            key_in = next_key;
            tag_in = next_tag;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      tag_ff <= tag_in;
      lt_ff  <= (key_ff < new_key);
      eq_ff  <= (key_ff == new_key);
   end

   assign key     = key_ff;
   assign tag     = tag_ff;
   assign lt_flag = lt_ff;
   assign eq_flag = eq_ff;
   // drive the read bus only at the addressed position
   assign sel_key = hit ? key_ff : '0;
   assign sel_tag = hit ? tag_ff : '0;

endmodule

### rtl/bounded_sorted_array_engine.sv
// Top level of the bounded sorted array engine: request control, search sequencer and cell row.
//
// Keeps up to CAPACITY (key, tag) entries sorted by signed key in a row of cells. A request is
// taken when start is high and busy is low; its single result shows on the rsp_ ports for one
// cycle with rsp_valid high and cannot be held off. Remove, checked remove, pop, clear and an
// insert into a full array first latch the request, then read the cell row over the position
// bus and, for a remove that succeeds, shift. An insert below capacity latches the request,
// sets the search bounds, then runs 1 to clog2(CAPACITY)+1 binary search steps, one step per
// cycle over per-cell compare flags; the shift happens in the last step. Busy falls in the same
// cycle that the result strobe rises, and the next request may be accepted at the edge that ends that cycle.
module bounded_sorted_array_engine (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [2:0]                         req_type,
   input  logic signed [bsae_pkg::KEY_W-1:0]  req_item_key,
   input  logic [bsae_pkg::TAG_W-1:0]         req_item_tag,
   input  logic [bsae_pkg::POS_W-1:0]         req_position,
   output logic                               rsp_valid,
   output logic [1:0]                         rsp_status,
   output logic [bsae_pkg::POS_W-1:0]         rsp_where_index,
   output logic signed [bsae_pkg::KEY_W-1:0]  rsp_out_key,
   output logic [bsae_pkg::TAG_W-1:0]         rsp_out_tag,
   output logic [bsae_pkg::FILL_W-1:0]        rsp_fill_count
);

   localparam int CAP   = bsae_pkg::CAPACITY;
   localparam int CNT_W = bsae_pkg::CNT_W;
   localparam int PTR_W = bsae_pkg::PTR_W;
   localparam int IDX_W = bsae_pkg::IDX_W;

   bsae_pkg::state_type state_ff, state_in;

   logic [2:0]                        type_ff;
   logic signed [bsae_pkg::KEY_W-1:0] key_ff;
   logic [bsae_pkg::TAG_W-1:0]        tag_ff;
   logic [bsae_pkg::POS_W-1:0]        pos_ff;
   logic [CNT_W-1:0]                  count_ff, count_in;
   logic [CNT_W-1:0]                  lo_ff, lo_in, hi_ff, hi_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [1:0]                        rsp_status_ff, rsp_status_in;
   logic [bsae_pkg::POS_W-1:0]        rsp_where_ff, rsp_where_in;
   logic signed [bsae_pkg::KEY_W-1:0] rsp_key_ff, rsp_key_in;
   logic [bsae_pkg::TAG_W-1:0]        rsp_tag_ff, rsp_tag_in;
   logic [bsae_pkg::FILL_W-1:0]       rsp_fill_ff, rsp_fill_in;

   bsae_pkg::cell_ctrl_type           ctrl;

   logic signed [bsae_pkg::KEY_W-1:0] cell_key [CAP];
   logic [bsae_pkg::TAG_W-1:0]        cell_tag [CAP];
   logic signed [bsae_pkg::KEY_W-1:0] cell_sel_key [CAP];
   logic [bsae_pkg::TAG_W-1:0]        cell_sel_tag [CAP];
   logic [CAP-1:0]                    lt_vec, eq_vec;

   logic signed [bsae_pkg::KEY_W-1:0] bus_key;
   logic [bsae_pkg::TAG_W-1:0]        bus_tag;

   logic [CNT_W:0]                    mid_sum;
   logic [CNT_W-1:0]                  mid;
   logic [IDX_W-1:0]                  mid_idx;
   logic                              search_more, hit, done_search;
   logic [PTR_W-1:0]                  ins_at;
   logic [PTR_W-1:0]                  rm_pos;
   logic                              in_range, rm_ok;
   logic                              accept;

   assign accept = start && !busy;
   assign busy   = (state_ff != bsae_pkg::ST_IDLE);

   // search step over the registered compare flags
   assign mid_sum     = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid         = mid_sum[CNT_W:1];
   assign mid_idx     = mid[IDX_W-1:0];
   assign search_more = (lo_ff < hi_ff);
   assign hit         = search_more && eq_vec[mid_idx];
   assign done_search = !search_more || hit;
   assign ins_at      = hit ? PTR_W'(mid) : PTR_W'(lo_ff);

   // removal position and range check
   always_comb begin
      if (type_ff == bsae_pkg::REQ_POP) begin
         rm_pos   = PTR_W'(count_ff - CNT_W'(1));
         in_range = (count_ff != '0);
      end else begin
         rm_pos   = PTR_W'(pos_ff);
         in_range = (PTR_W'(pos_ff) < PTR_W'(count_ff));
      end
   end

   assign rm_ok = in_range && ((type_ff != bsae_pkg::REQ_CHECKED) || (bus_tag == tag_ff));

   // read bus: only the addressed cell drives nonzero
   always_comb begin
      bus_key = '0;
      bus_tag = '0;
      for (int i = 0; i < CAP; i++) begin
         bus_key = bus_key | cell_sel_key[i];
         bus_tag = bus_tag | cell_sel_tag[i];
      end
   end

   for (genvar g = 0; g < CAP; g++) begin : g_cell
      logic signed [bsae_pkg::KEY_W-1:0] prev_key, next_key;
      logic [bsae_pkg::TAG_W-1:0]        prev_tag, next_tag;

      if (g == 0) begin : g_first
         assign prev_key = '0;
         assign prev_tag = '0;
      end else begin : g_mid
         assign prev_key = cell_key[g-1];
         assign prev_tag = cell_tag[g-1];
      end

      if (g == CAP - 1) begin : g_last
         assign next_key = cell_key[g];
         assign next_tag = cell_tag[g];
      end else begin : g_body
         assign next_key = cell_key[g+1];
         assign next_tag = cell_tag[g+1];
      end

      bsae_cell u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .idx      (PTR_W'(g)),
         .new_key  (key_ff),
         .new_tag  (tag_ff),
         .prev_key (prev_key),
         .prev_tag (prev_tag),
         .next_key (next_key),
         .next_tag (next_tag),
         .key      (cell_key[g]),
         .tag      (cell_tag[g]),
         .lt_flag  (lt_vec[g]),
         .eq_flag  (eq_vec[g]),
         .sel_key  (cell_sel_key[g]),
         .sel_tag  (cell_sel_tag[g])
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bsae_pkg::ST_IDLE: begin
            if (start) state_in = bsae_pkg::ST_PREP;
         end
         bsae_pkg::ST_PREP: begin
            if ((type_ff == bsae_pkg::REQ_INSERT) && (count_ff < CNT_W'(CAP)))
               state_in = bsae_pkg::ST_SEARCH;
            else
               state_in = bsae_pkg::ST_IDLE;
         end
         bsae_pkg::ST_SEARCH: begin
            if (done_search) state_in = bsae_pkg::ST_IDLE;
         end
         default: state_in = bsae_pkg::ST_IDLE;
      endcase
   end

   // datapath control and result
   always_comb begin
      ctrl.ins      = 1'b0;
      ctrl.rem      = 1'b0;
      ctrl.at       = rm_pos;
      count_in      = count_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = bsae_pkg::STAT_DONE;
      rsp_where_in  = '0;
      rsp_key_in    = '0;
      rsp_tag_in    = '0;
      case (state_ff)
         bsae_pkg::ST_PREP: begin
            rsp_valid_in = 1'b1;
            case (type_ff)
               bsae_pkg::REQ_INSERT: begin
                  if (count_ff >= CNT_W'(CAP)) begin
                     rsp_status_in = bsae_pkg::STAT_FULL;
                  end else begin
                     rsp_valid_in = 1'b0;
                     lo_in        = '0;
                     hi_in        = count_ff;
                  end
               end
               bsae_pkg::REQ_REMOVE, bsae_pkg::REQ_CHECKED, bsae_pkg::REQ_POP: begin
                  if (rm_ok) begin
                     ctrl.rem     = 1'b1;
                     count_in     = count_ff - CNT_W'(1);
                     rsp_where_in = rm_pos[bsae_pkg::POS_W-1:0];
                     rsp_key_in   = bus_key;
                     rsp_tag_in   = bus_tag;
                  end else begin
                     rsp_status_in = bsae_pkg::STAT_BAD;
                  end
               end
               bsae_pkg::REQ_CLEAR: begin
                  count_in = '0;
               end
               default: begin
                  rsp_status_in = bsae_pkg::STAT_BAD;
               end
            endcase
         end
         bsae_pkg::ST_SEARCH: begin
            if (done_search) begin
               ctrl.ins     = 1'b1;
               ctrl.at      = ins_at;
               count_in     = count_ff + CNT_W'(1);
               rsp_valid_in = 1'b1;
               rsp_where_in = ins_at[bsae_pkg::POS_W-1:0];
            end else if (lt_vec[mid_idx]) begin
               lo_in = mid + CNT_W'(1);
            end else begin
               hi_in = mid;
            end
         end
         default: begin
         end
      endcase
      rsp_fill_in = bsae_pkg::FILL_W'(PTR_W'(count_in));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bsae_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         type_ff <= req_type;
         key_ff  <= req_item_key;
         tag_ff  <= req_item_tag;
         pos_ff  <= req_position;
      end
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      rsp_status_ff <= rsp_status_in;
      rsp_where_ff  <= rsp_where_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_fill_ff   <= rsp_fill_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_where_index = rsp_where_ff;
   assign rsp_out_key     = rsp_key_ff;
   assign rsp_out_tag     = rsp_tag_ff;
   assign rsp_fill_count  = rsp_fill_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAP))
      else $error("entry count above capacity");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted request did not raise busy");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   a_search_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bsae_pkg::ST_SEARCH) |-> (lo_ff <= hi_ff) && (hi_ff <= count_ff))
      else $error("search bounds crossed");

   a_no_dual_shift: assert property (@(posedge clock) disable iff (reset)
      !(ctrl.ins && ctrl.rem))
      else $error("insert and remove shift in the same cycle");
`endif

endmodule
